// ===== src/lcc_pkg.sv =====
`timescale 1ns / 1ps
package lcc_pkg;
    localparam int CordicSteps = 16;
    localparam int StepBits = 5;
    localparam int MaxReadings = 1024;
    localparam int CountBits = 11;
    localparam int SumBits = 28;
    localparam logic signed [22:0] PiQ16 = 23'sd205887;
    localparam logic signed [22:0] TwoPiQ16 = 23'sd411775;
    localparam logic signed [22:0] HalfPiQ16 = 23'sd102944;
    localparam logic signed [19:0] GainQ15 = 20'sd19898;
    localparam logic [15:0] WallReset = 16'd1000;
    localparam logic [1:0] ClassNone = 2'd0;
    localparam logic [1:0] ClassCone = 2'd1;
    localparam logic [1:0] ClassWall = 2'd2;

    function automatic logic signed [22:0] atan_q16(input logic [StepBits-1:0] i);
        case (i)
            5'd0: atan_q16 = 23'sd51472;
            5'd1: atan_q16 = 23'sd30386;
            5'd2: atan_q16 = 23'sd16055;
            5'd3: atan_q16 = 23'sd8150;
            5'd4: atan_q16 = 23'sd4091;
            5'd5: atan_q16 = 23'sd2047;
            5'd6: atan_q16 = 23'sd1024;
            5'd7: atan_q16 = 23'sd512;
            5'd8: atan_q16 = 23'sd256;
            5'd9: atan_q16 = 23'sd128;
            5'd10: atan_q16 = 23'sd64;
            5'd11: atan_q16 = 23'sd32;
            5'd12: atan_q16 = 23'sd16;
            5'd13: atan_q16 = 23'sd8;
            5'd14: atan_q16 = 23'sd4;
            5'd15: atan_q16 = 23'sd2;
            5'd16: atan_q16 = 23'sd1;
            default: atan_q16 = 23'sd0;
        endcase
    endfunction

    typedef struct packed {
        logic signed [17:0] cos_q15;
        logic signed [17:0] sin_q15;
    } t_trig;
endpackage

// ===== src/lidar_cluster_classifier.sv =====
`timescale 1ns / 1ps
// Obstacle accumulator and classifier for lidar readings.
// Slave channel: one item per reading; tdata = {reading_angle, reading_range}
// from the lowest bit, tuser = has_reading, tlast = last_reading.
// Master channel: one result item per item marked last; tdata = {center_x,
// center_y, reading_count} from the lowest bit, tuser = obstacle_class.
// A config channel writes wall_length_mm (reset 1000) while the block is idle.
// Each of the first 1024 readings of an obstacle runs through one shared
// CORDIC (16 iterations) and two multiply steps before the next item is taken.
// An item marked last then runs the CORDIC again on the edge angle difference,
// six multiply steps for the chord test and two restoring divisions over the
// 28 sum bits for the centroid; an empty obstacle skips straight to the result.
// The block accepts no item during that work; it is ready for the next item
// again once the result is loaded and the state returns to idle.
// The result waits in the output register; readings of the next obstacle are
// still taken, but its last item holds the block until the result is taken.
// Reset clears the sums, count, edges and the output valid flag.
module lidar_cluster_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // reading_angle, reading_range
    input  logic        s_axis_tuser,   // has_reading
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // center_x, center_y, reading_count
    output logic [1:0]  m_axis_tuser,   // obstacle_class
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PT    = 9'b000000010,
        S_PMUL  = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_CH    = 9'b000010000,
        S_CHMUL = 9'b000100000,
        S_DIVX  = 9'b001000000,
        S_DIVY  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [15:0] r_wall;
    logic r_last;
    logic signed [15:0] r_ang;
    logic [15:0] r_rng;
    logic [lcc_pkg::SumBits-1:0] r_sx, r_sy;
    logic [lcc_pkg::CountBits-1:0] r_cnt;
    logic signed [15:0] r_lo_a, r_hi_a;
    logic [15:0] r_lo_r, r_hi_r;
    logic [2:0] r_step;
    logic [4:0] r_bit;
    logic signed [17:0] r_cos, r_sin;
    logic signed [51:0] r_acc;
    logic [31:0] r_ab;
    // division
    logic [27:0] r_q;
    logic [9:0] r_rem;
    logic r_dneg;
    logic [1:0] r_cls;
    logic [16:0] r_cx, r_cy;
    logic [47:0] r_odata;
    logic [1:0] r_ouser;
    logic r_ovalid;

    logic in_acc, has, lst, out_load;
    logic signed [15:0] ang;
    logic [15:0] rng;
    logic cstart, cdone;
    logic signed [19:0] cangle;
    lcc_pkg::t_trig trig;
    logic signed [34:0] prod;
    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [16:0] diff;
    logic [10:0] rem_sh, rem_sub;
    logic div_ge;
    logic [27:0] q_next, q_fin, sx_abs, sy_abs;

    assign has = s_axis_tuser;
    assign ang = s_axis_tdata[15:0];
    assign rng = s_axis_tdata[31:16];
    assign lst = s_axis_tlast;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = (r_state == S_IDLE);

    assign diff = 17'(r_hi_a) - 17'(r_lo_a);
    assign cstart = (in_acc && has && (r_cnt < 11'(lcc_pkg::MaxReadings)))
                    || (r_state == S_CHK && r_cnt != '0);
    assign cangle = (r_state == S_CHK) ? 20'(diff) * 20'sd8 : 20'(ang) * 20'sd8;

    lcc_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cstart),
        .i_angle(cangle), .o_done(cdone), .o_trig(trig)
    );

    // the single multiplier: 17 x 18 signed, selected by sequencer step
    always_comb begin
        mul_a = $signed({1'b0, r_rng});
        mul_b = r_cos;
        if (r_state == S_PMUL) begin
            if (r_step != 3'd0) mul_b = r_sin;
        end else begin
            case (r_step)
                3'd0: begin
                    mul_a = $signed({1'b0, r_lo_r}); mul_b = $signed({2'b0, r_lo_r});
                end
                3'd1: begin
                    mul_a = $signed({1'b0, r_hi_r}); mul_b = $signed({2'b0, r_hi_r});
                end
                3'd2: begin
                    mul_a = $signed({1'b0, r_lo_r}); mul_b = $signed({2'b0, r_hi_r});
                end
                3'd3: begin
                    mul_a = $signed({1'b0, r_ab[15:0]}); mul_b = r_cos;
                end
                3'd4: begin
                    mul_a = $signed({1'b0, r_ab[31:16]}); mul_b = r_cos;
                end
                default: begin
                    mul_a = $signed({1'b0, r_wall}); mul_b = $signed({2'b0, r_wall});
                end
            endcase
        end
        prod = 35'(mul_a) * 35'(mul_b);
    end

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign rem_sh = {r_rem, r_q[27]};
    assign div_ge = (rem_sh >= r_cnt);
    assign rem_sub = rem_sh - r_cnt;
    assign q_next = {r_q[26:0], div_ge};
    assign q_fin = r_dneg ? (28'd0 - q_next) : q_next;
    assign sx_abs = r_sx[27] ? (28'd0 - r_sx) : r_sx;
    assign sy_abs = r_sy[27] ? (28'd0 - r_sy) : r_sy;

    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wall <= lcc_pkg::WallReset;
            r_sx <= '0; r_sy <= '0; r_cnt <= '0;
            r_lo_a <= '0; r_hi_a <= '0; r_lo_r <= '0; r_hi_r <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_wall <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= lst;
                        r_ang <= ang;
                        r_rng <= rng;
                        if (has && r_cnt < 11'(lcc_pkg::MaxReadings)) r_state <= S_PT;
                        else if (lst) r_state <= S_CHK;
                    end
                end
                S_PT: begin
                    if (cdone) begin
                        r_cos <= trig.cos_q15; r_sin <= trig.sin_q15;
                        r_step <= '0;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    // round to mm and add into the sums; the second step also updates the edges and count
                    if (r_step == 3'd0) begin
                        r_sx <= r_sx + 28'((prod + 35'sd16384) >>> 15);
                        r_step <= 3'd1;
                    end else begin
                        r_sy <= r_sy + 28'((prod + 35'sd16384) >>> 15);
                        if (r_cnt == '0 || r_ang < r_lo_a) begin
                            r_lo_a <= r_ang; r_lo_r <= r_rng;
                        end
                        if (r_cnt == '0 || r_ang >= r_hi_a) begin
                            r_hi_a <= r_ang; r_hi_r <= r_rng;
                        end
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= r_last ? S_CHK : S_IDLE;
                    end
                end
                S_CHK: begin
                    if (r_cnt == '0) begin
                        r_cls <= lcc_pkg::ClassNone; r_cx <= '0; r_cy <= '0;
                        r_state <= S_OUT;
                    end else r_state <= S_CH;
                end
                S_CH: begin
                    if (cdone) begin
                        r_cos <= trig.cos_q15;
                        r_step <= '0;
                        r_state <= S_CHMUL;
                    end
                end
                S_CHMUL: begin
                    // (a*a + b*b) * 2^15 - 2*a*b*cos against wall^2 * 2^15
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: r_acc <= 52'(prod) <<< 15;
                        3'd1: r_acc <= r_acc + (52'(prod) <<< 15);
                        3'd2: r_ab <= 32'(prod);
                        3'd3: r_acc <= r_acc - (52'(prod) <<< 1);
                        3'd4: r_acc <= r_acc - (52'(prod) <<< 17);
                        default: begin
                            r_cls <= (r_acc > (52'(prod) <<< 15)) ? lcc_pkg::ClassWall
                                                                 : lcc_pkg::ClassCone;
                            r_q <= sx_abs; r_dneg <= r_sx[27];
                            r_rem <= '0; r_bit <= '0;
                            r_state <= S_DIVX;
                        end
                    endcase
                end
                S_DIVX: begin
                    if (r_bit == 5'(lcc_pkg::SumBits - 1)) begin
                        r_cx <= 17'(q_fin);
                        r_q <= sy_abs; r_dneg <= r_sy[27];
                        r_rem <= '0; r_bit <= '0;
                        r_state <= S_DIVY;
                    end else begin
                        r_q <= q_next;
                        r_rem <= div_ge ? 10'(rem_sub) : 10'(rem_sh);
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_DIVY: begin
                    if (r_bit == 5'(lcc_pkg::SumBits - 1)) begin
                        r_cy <= 17'(q_fin);
                        r_state <= S_OUT;
                    end else begin
                        r_q <= q_next;
                        r_rem <= div_ge ? 10'(rem_sub) : 10'(rem_sh);
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free, then clear the obstacle
                    if (out_load) begin
                        r_sx <= '0; r_sy <= '0; r_cnt <= '0;
                        r_lo_a <= '0; r_hi_a <= '0; r_lo_r <= '0; r_hi_r <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (out_load) begin
            r_odata <= {3'b0, r_cnt, r_cy, r_cx};
            r_ouser <= r_cls;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata) && $stable(r_ouser)))
        else $error("result changed while waiting");
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 11'(lcc_pkg::MaxReadings))
        else $error("reading count beyond limit");
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ouser == lcc_pkg::ClassNone || r_ouser == lcc_pkg::ClassCone ||
                      r_ouser == lcc_pkg::ClassWall))
        else $error("bad class code");
endmodule

// ===== src/lcc_cordic.sv =====
`timescale 1ns / 1ps
module lcc_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [19:0]  i_angle,
    output logic                o_done,
    output lcc_pkg::t_trig      o_trig
);
    logic signed [22:0] z0, z1, z2;
    logic neg0;
    logic signed [22:0] r_z, n_z;
    logic signed [19:0] r_x, n_x, r_y, n_y;
    logic r_neg, r_busy, n_busy, r_done;
    logic [lcc_pkg::StepBits-1:0] r_i, n_i;
    logic signed [19:0] dx, dy, fx, fy;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        z0 = 23'(i_angle);
        z1 = z0;
        if (z0 > lcc_pkg::PiQ16) z1 = z0 - lcc_pkg::TwoPiQ16;
        else if (z0 < -lcc_pkg::PiQ16) z1 = z0 + lcc_pkg::TwoPiQ16;
        z2 = z1;
        neg0 = 1'b0;
        if (z1 > lcc_pkg::HalfPiQ16) begin
            z2 = z1 - lcc_pkg::PiQ16; neg0 = 1'b1;
        end else if (z1 < -lcc_pkg::HalfPiQ16) begin
            z2 = z1 + lcc_pkg::PiQ16; neg0 = 1'b1;
        end
    end

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i; n_busy = r_busy;
        if (i_start) begin
            n_x = lcc_pkg::GainQ15; n_y = '0; n_z = z2; n_i = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - dx; n_y = r_y + dy; n_z = r_z - lcc_pkg::atan_q16(r_i);
            end else begin
                n_x = r_x + dx; n_y = r_y - dy; n_z = r_z + lcc_pkg::atan_q16(r_i);
            end
            n_i = r_i + 1'b1;
            if (r_i == lcc_pkg::StepBits'(lcc_pkg::CordicSteps - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_i <= n_i;
        if (i_start) r_neg <= neg0;
    end

    always_comb begin
        fx = r_neg ? -r_x : r_x;
        fy = r_neg ? -r_y : r_y;
        o_trig.cos_q15 = (fx > 20'sd32768) ? 18'sd32768 :
                         (fx < -20'sd32768) ? -18'sd32768 : 18'(fx);
        o_trig.sin_q15 = (fy > 20'sd32768) ? 18'sd32768 :
                         (fy < -20'sd32768) ? -18'sd32768 : 18'(fy);
    end
    assign o_done = r_done;
endmodule
